FILE: rtl/core/ftvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftvm_pkg : shared types and constants of the tensor-vector multiply core
// Complex word layout, register codes, component codes and the fixed-point
// widths used along the multiply datapath.
// ----------------------------------------------------------------------------
package ftvm_pkg;

    // Store and datapath sizing
    localparam int COMPONENTS = 6;
    localparam int AXES       = 3;
    localparam int QUAD_DEPTH = 32768;
    localparam int FRAC_BITS  = 24;
    localparam int WORD_W     = 32;
    localparam int IDX_W      = 7;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int COMP_W     = 3;
    localparam int TERM_IDX_W = 16;           // quad_y * z + y
    localparam int RAW_ADDR_W = 25;           // quad_x * (..) + x, before range check
    localparam int PROD_W     = 2 * WORD_W;   // exact 32x32 product
    localparam int TERM_W     = PROD_W + 1;   // signed sum or difference of two products
    localparam int SUM_W      = TERM_W + 2;   // three terms plus rounding half

    // Stream payload widths
    localparam int S_TDATA_W = 216;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 192;

    // Result buffer
    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Saturation limits
    localparam logic [WORD_W-1:0] SAT_POS = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] SAT_NEG = {1'b1, {(WORD_W-1){1'b0}}};

    // Transaction kind carried in tuser
    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_MULT  = 1'b1
    } action_e;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAD_X   = 3'd0,
        REG_QUAD_Y   = 3'd1,
        REG_QUAD_Z   = 3'd2,
        REG_PADDED_X = 3'd3,
        REG_PADDED_Y = 3'd4,
        REG_PADDED_Z = 3'd5
    } cfg_reg_e;

    // Tensor component codes
    typedef enum logic [COMP_W-1:0] {
        COMP_XX = 3'd0,
        COMP_XY = 3'd1,
        COMP_XZ = 3'd2,
        COMP_YY = 3'd3,
        COMP_YZ = 3'd4,
        COMP_ZZ = 3'd5
    } comp_e;

    // Symmetric tensor: row/column to stored component
    localparam int COMP_MAP [AXES][AXES] = '{
        '{int'(COMP_XX), int'(COMP_XY), int'(COMP_XZ)},
        '{int'(COMP_XY), int'(COMP_YY), int'(COMP_YZ)},
        '{int'(COMP_XZ), int'(COMP_YZ), int'(COMP_ZZ)}
    };

    // Complex Q8.24 word, real part in the low half
    typedef struct packed {
        logic signed [WORD_W-1:0] im;
        logic signed [WORD_W-1:0] re;
    } cplx_t;

    // Complex 3-vector, x in the low bits
    typedef struct packed {
        cplx_t z;
        cplx_t y;
        cplx_t x;
    } vec3_t;

    typedef cplx_t [AXES-1:0]       cvec_t;
    typedef cplx_t [COMPONENTS-1:0] tensor_t;

    typedef struct packed {
        logic [CFG_W-1:0] quad_x;
        logic [CFG_W-1:0] quad_y;
        logic [CFG_W-1:0] quad_z;
        logic [CFG_W-1:0] padded_x;
        logic [CFG_W-1:0] padded_y;
        logic [CFG_W-1:0] padded_z;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        quad_x:   8'd64,
        quad_y:   8'd64,
        quad_z:   8'd64,
        padded_x: 8'd128,
        padded_y: 8'd128,
        padded_z: 8'd128
    };

    // Item travelling alongside the address computation
    typedef struct packed {
        action_e           action;
        logic [COMP_W-1:0] comp;
        logic [AXES-1:0]   neg;     // axis mirrored, bit 0 = x
        vec3_t             vec;
    } item_t;

endpackage

FILE: rtl/core/ftvm_addr_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftvm_addr_gen : mirroring and quadrant address pipeline
// Three stages: mirror the grid point into the stored quadrant, form
// quad_y*z + y, then quad_x*(..) + x. Flags addresses beyond the store.
// ----------------------------------------------------------------------------
module ftvm_addr_gen #(
    parameter int QUAD_DEPTH = ftvm_pkg::QUAD_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ftvm_pkg::cfg_t                  cfg,
    input  logic                            in_valid,
    input  ftvm_pkg::action_e               in_action,
    input  logic [ftvm_pkg::IDX_W-1:0]      in_x,
    input  logic [ftvm_pkg::IDX_W-1:0]      in_y,
    input  logic [ftvm_pkg::IDX_W-1:0]      in_z,
    input  logic [ftvm_pkg::COMP_W-1:0]     in_comp,
    input  ftvm_pkg::vec3_t                 in_vec,
    output logic                            out_valid,
    output ftvm_pkg::item_t                 out_item,
    output logic [$clog2(QUAD_DEPTH)-1:0]   out_addr,
    output logic                            out_in_range
);

    localparam int AW = $clog2(QUAD_DEPTH);
    localparam int CW = ftvm_pkg::CFG_W;
    localparam int TW = ftvm_pkg::TERM_IDX_W;
    localparam int RW = ftvm_pkg::RAW_ADDR_W;

    // Mirror one index past its extent on a multiply; top bit flags the sign flip
    function automatic logic [CW:0] mirror_idx(input logic [ftvm_pkg::IDX_W-1:0] idx,
                                               input logic [CW-1:0] quad,
                                               input logic [CW-1:0] pad,
                                               input logic mul);
        logic [CW-1:0] wide;
        logic [CW:0]   res;
        wide = {1'b0, idx};
        if (mul && (wide >= quad)) begin
            res = {1'b1, pad - wide};
        end else begin
            res = {1'b0, wide};
        end
        return res;
    endfunction

    logic [CW:0]     mx, my, mz;
    logic            is_mul;

    logic            va_reg, vb_reg, vc_reg;
    ftvm_pkg::item_t item_a_reg, item_b_reg, item_c_reg;
    logic [CW-1:0]   xa_reg, ya_reg, za_reg, xb_reg;
    logic [TW-1:0]   tb_reg;
    logic [RW-1:0]   addr_c_reg;

    assign is_mul = (in_action == ftvm_pkg::ACT_MULT);
    assign mx     = mirror_idx(in_x, cfg.quad_x, cfg.padded_x, is_mul);
    assign my     = mirror_idx(in_y, cfg.quad_y, cfg.padded_y, is_mul);
    assign mz     = mirror_idx(in_z, cfg.quad_z, cfg.padded_z, is_mul);

    // Valid pipe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    // Stage a: mirrored point
    always_ff @(posedge aclk) begin
        item_a_reg.action <= in_action;
        item_a_reg.comp   <= in_comp;
        item_a_reg.neg    <= {mz[CW], my[CW], mx[CW]};
        item_a_reg.vec    <= in_vec;
        xa_reg            <= mx[CW-1:0];
        ya_reg            <= my[CW-1:0];
        za_reg            <= mz[CW-1:0];
    end

    // Stage b: quad_y * z + y
    always_ff @(posedge aclk) begin
        item_b_reg <= item_a_reg;
        xb_reg     <= xa_reg;
        tb_reg     <= ({{(TW-CW){1'b0}}, cfg.quad_y} * {{(TW-CW){1'b0}}, za_reg})
                      + {{(TW-CW){1'b0}}, ya_reg};
    end

    // Stage c: quad_x * (..) + x
    always_ff @(posedge aclk) begin
        item_c_reg <= item_b_reg;
        addr_c_reg <= ({{(RW-CW){1'b0}}, cfg.quad_x} * {{(RW-TW){1'b0}}, tb_reg})
                      + {{(RW-CW){1'b0}}, xb_reg};
    end

    assign out_valid    = vc_reg;
    assign out_item     = item_c_reg;
    assign out_addr     = addr_c_reg[AW-1:0];
    assign out_in_range = (addr_c_reg < RW'(QUAD_DEPTH));

endmodule

FILE: rtl/core/ftvm_tensor_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftvm_tensor_mem : component store of the symmetric tensor
// One synchronous memory holding a word of six component lanes per quadrant
// point. A write hits one lane; a read returns all six in the next cycle.
// ----------------------------------------------------------------------------
module ftvm_tensor_mem #(
    parameter int QUAD_DEPTH = ftvm_pkg::QUAD_DEPTH
) (
    input  logic                               aclk,
    input  logic [$clog2(QUAD_DEPTH)-1:0]      addr,
    input  logic                               wr_en,
    input  logic [ftvm_pkg::COMP_W-1:0]        wr_comp,
    input  ftvm_pkg::cplx_t                    wr_data,
    input  logic                               rd_en,
    output ftvm_pkg::tensor_t                  rd_data
);

    ftvm_pkg::tensor_t mem [QUAD_DEPTH];
    ftvm_pkg::tensor_t rd_word_reg;

    // One port: write one component lane or registered read of all six
    always_ff @(posedge aclk) begin
        for (int c = 0; c < ftvm_pkg::COMPONENTS; c++) begin
            if (wr_en && (wr_comp == ftvm_pkg::COMP_W'(c))) begin
                mem[addr][c] <= wr_data;
            end
        end
        if (rd_en) begin
            rd_word_reg <= mem[addr];
        end
    end

    assign rd_data = rd_word_reg;

endmodule

FILE: rtl/core/ftvm_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftvm_mac : complex 3x3 symmetric tensor times vector
// Four stages: exact products, signed pair terms, row sums with the rounding
// half, then shift to Q8.24 and saturate.
// ----------------------------------------------------------------------------
module ftvm_mac (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    input  logic                           in_zero,     // tensor read beyond store
    input  ftvm_pkg::tensor_t              in_tensor,
    input  ftvm_pkg::vec3_t                in_vec,
    input  logic [ftvm_pkg::AXES-1:0]      in_neg,
    output logic                           out_valid,
    output ftvm_pkg::vec3_t                out_result
);

    localparam int AXES   = ftvm_pkg::AXES;
    localparam int PROD_W = ftvm_pkg::PROD_W;
    localparam int TERM_W = ftvm_pkg::TERM_W;
    localparam int SUM_W  = ftvm_pkg::SUM_W;
    localparam int WORD_W = ftvm_pkg::WORD_W;
    localparam int FRAC_BITS = ftvm_pkg::FRAC_BITS;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

    ftvm_pkg::cplx_t mat [AXES][AXES];
    ftvm_pkg::cvec_t vec_arr;

    logic                     ve_reg, vf_reg, vg_reg, vh_reg;
    logic [AXES-1:0]          neg_e_reg;
    logic signed [PROD_W-1:0] prr_reg [AXES][AXES];
    logic signed [PROD_W-1:0] pii_reg [AXES][AXES];
    logic signed [PROD_W-1:0] pri_reg [AXES][AXES];
    logic signed [PROD_W-1:0] pir_reg [AXES][AXES];
    logic signed [TERM_W-1:0] re_t    [AXES][AXES];
    logic signed [TERM_W-1:0] im_t    [AXES][AXES];
    logic signed [TERM_W-1:0] re_term_reg [AXES][AXES];
    logic signed [TERM_W-1:0] im_term_reg [AXES][AXES];
    logic signed [SUM_W-1:0]  re_sum_reg [AXES];
    logic signed [SUM_W-1:0]  im_sum_reg [AXES];
    logic signed [SUM_W-1:0]  re_sh [AXES];
    logic signed [SUM_W-1:0]  im_sh [AXES];
    ftvm_pkg::cvec_t          res;
    ftvm_pkg::cvec_t          res_reg;

    // Valid pipe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
            vh_reg <= 1'b0;
        end else begin
            ve_reg <= in_valid;
            vf_reg <= ve_reg;
            vg_reg <= vf_reg;
            vh_reg <= vg_reg;
        end
    end

    // Expand the six stored components into the full matrix
    assign vec_arr = in_vec;
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            for (int j = 0; j < AXES; j++) begin
                mat[i][j] = in_zero ? '0 : in_tensor[ftvm_pkg::COMP_MAP[i][j]];
            end
        end
    end

    // Stage e: exact products, 32x32 signed on sign-extended operands
    always_ff @(posedge aclk) begin
        neg_e_reg <= in_neg;
        for (int i = 0; i < AXES; i++) begin
            for (int j = 0; j < AXES; j++) begin
                prr_reg[i][j] <= PROD_W'(mat[i][j].re) * PROD_W'(vec_arr[j].re);
                pii_reg[i][j] <= PROD_W'(mat[i][j].im) * PROD_W'(vec_arr[j].im);
                pri_reg[i][j] <= PROD_W'(mat[i][j].re) * PROD_W'(vec_arr[j].im);
                pir_reg[i][j] <= PROD_W'(mat[i][j].im) * PROD_W'(vec_arr[j].re);
            end
        end
    end

    // Stage f: complex terms, off-diagonal sign from the two mirrored axes
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            for (int j = 0; j < AXES; j++) begin
                re_t[i][j] = TERM_W'(prr_reg[i][j]) - TERM_W'(pii_reg[i][j]);
                im_t[i][j] = TERM_W'(pri_reg[i][j]) + TERM_W'(pir_reg[i][j]);
                if ((i != j) && (neg_e_reg[i] ^ neg_e_reg[j])) begin
                    re_t[i][j] = -re_t[i][j];
                    im_t[i][j] = -im_t[i][j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        re_term_reg <= re_t;
        im_term_reg <= im_t;
    end

    // Stage g: row sums plus half an LSB
    always_ff @(posedge aclk) begin
        for (int i = 0; i < AXES; i++) begin
            re_sum_reg[i] <= SUM_W'(re_term_reg[i][0]) + SUM_W'(re_term_reg[i][1])
                             + SUM_W'(re_term_reg[i][2]) + HALF;
            im_sum_reg[i] <= SUM_W'(im_term_reg[i][0]) + SUM_W'(im_term_reg[i][1])
                             + SUM_W'(im_term_reg[i][2]) + HALF;
        end
    end

    // Stage h: floor to Q8.24 and clamp to the word range
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            re_sh[i] = re_sum_reg[i] >>> FRAC_BITS;
            im_sh[i] = im_sum_reg[i] >>> FRAC_BITS;
            if ((&re_sh[i][SUM_W-1:WORD_W-1]) || !(|re_sh[i][SUM_W-1:WORD_W-1])) begin
                res[i].re = re_sh[i][WORD_W-1:0];
            end else begin
                res[i].re = re_sh[i][SUM_W-1] ? ftvm_pkg::SAT_NEG : ftvm_pkg::SAT_POS;
            end
            if ((&im_sh[i][SUM_W-1:WORD_W-1]) || !(|im_sh[i][SUM_W-1:WORD_W-1])) begin
                res[i].im = im_sh[i][WORD_W-1:0];
            end else begin
                res[i].im = im_sh[i][SUM_W-1] ? ftvm_pkg::SAT_NEG : ftvm_pkg::SAT_POS;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res;
    end

    assign out_valid  = vh_reg;
    assign out_result = res_reg;

endmodule

FILE: rtl/core/ftvm_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftvm_out_fifo : result buffer in front of the master stream
// Small register FIFO; the top level grants input only while a slot is
// reserved for every multiply in flight, so a push never finds it full.
// ----------------------------------------------------------------------------
module ftvm_out_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ftvm_pkg::vec3_t    push_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ftvm_pkg::vec3_t    m_data
);

    localparam int PTR_W = ftvm_pkg::PTR_W;
    localparam int CNT_W = ftvm_pkg::CNT_W;

    ftvm_pkg::vec3_t   entry_reg [ftvm_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;

    assign m_valid = (count_reg != '0);
    assign m_data  = entry_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    // Pointer and fill level update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!push && pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/fourier_tensor_vector_multiply_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fourier_tensor_vector_multiply_core : Fourier-domain tensor-vector multiply
//
//   Channel   Dir  Handshake          Payload
//   s_*       in   s_tvalid/s_tready  tuser: kind (write/multiply), tdata: point,
//                                     component, complex vector or tensor word
//   m_*       out  m_tvalid/m_tready  tdata: complex result vector
//   cfg_*     in   cfg_wr_en          cfg_index, cfg_wdata (no read-back)
//
// One transaction per cycle on s_* while s_tready is high. After acceptance a
// multiply result passes three address stages, the component memory read, four
// arithmetic stages and the result buffer write; the single address port of
// the component memory sets the one-per-cycle rate. Reset clears control and
// loads the register defaults; the tensor store is not cleared. s_tready falls
// while FIFO_DEPTH multiplies are outstanding between input and m_* handshake.
// ----------------------------------------------------------------------------
module fourier_tensor_vector_multiply_core #(
    parameter int QUAD_DEPTH = ftvm_pkg::QUAD_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // x_index, y_index, z_index, component, vx_re, vx_im, vy_re, vy_im, vz_re, vz_im
    input  logic [ftvm_pkg::S_TDATA_W-1:0]      s_tdata,
    // action
    input  logic [ftvm_pkg::S_TUSER_W-1:0]      s_tuser,
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // rx_re, rx_im, ry_re, ry_im, rz_re, rz_im
    output logic [ftvm_pkg::M_TDATA_W-1:0]      m_tdata,
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [ftvm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ftvm_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam int AW    = $clog2(QUAD_DEPTH);
    localparam int CNT_W = ftvm_pkg::CNT_W;
    localparam int IW    = ftvm_pkg::IDX_W;
    localparam int CPW   = ftvm_pkg::COMP_W;
    localparam int VEC_LSB = 3 * IW + CPW;

    ftvm_pkg::cfg_t        cfg_reg;
    logic [CNT_W-1:0]      credit_reg, credit_next;

    ftvm_pkg::action_e     in_action;
    ftvm_pkg::vec3_t       in_vec;
    logic                  accept, mult_accept, pop;

    logic                  c_valid, c_in_range;
    ftvm_pkg::item_t       c_item;
    logic [AW-1:0]         c_addr;
    logic                  mem_wr_en, mem_rd_en;
    ftvm_pkg::tensor_t     mem_rd_data;

    logic                  d_valid_reg, d_zero_reg;
    logic [ftvm_pkg::AXES-1:0] d_neg_reg;
    ftvm_pkg::vec3_t       d_vec_reg;

    logic                  mac_valid;
    ftvm_pkg::vec3_t       mac_result;
    ftvm_pkg::vec3_t       fifo_data;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= ftvm_pkg::CFG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ftvm_pkg::REG_QUAD_X:   cfg_reg.quad_x   <= cfg_wdata;
                ftvm_pkg::REG_QUAD_Y:   cfg_reg.quad_y   <= cfg_wdata;
                ftvm_pkg::REG_QUAD_Z:   cfg_reg.quad_z   <= cfg_wdata;
                ftvm_pkg::REG_PADDED_X: cfg_reg.padded_x <= cfg_wdata;
                ftvm_pkg::REG_PADDED_Y: cfg_reg.padded_y <= cfg_wdata;
                ftvm_pkg::REG_PADDED_Z: cfg_reg.padded_z <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input unpacking
    assign in_action   = ftvm_pkg::action_e'(s_tuser[0]);
    assign in_vec      = s_tdata[ftvm_pkg::S_TDATA_W-1:VEC_LSB];
    assign accept      = s_tvalid && s_tready;
    assign mult_accept = accept && (in_action == ftvm_pkg::ACT_MULT);
    assign pop         = m_tvalid && m_tready;

    // Result slots reserved per multiply in flight
    always_comb begin
        credit_next = credit_reg;
        if (mult_accept && !pop) begin
            credit_next = credit_reg + CNT_W'(1);
        end else if (!mult_accept && pop) begin
            credit_next = credit_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_next;
        end
    end

    assign s_tready = (credit_reg < CNT_W'(ftvm_pkg::FIFO_DEPTH));

    // Address pipeline
    ftvm_addr_gen #(
        .QUAD_DEPTH (QUAD_DEPTH)
    ) u_addr_gen (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .in_valid     (accept),
        .in_action    (in_action),
        .in_x         (s_tdata[IW-1:0]),
        .in_y         (s_tdata[2*IW-1:IW]),
        .in_z         (s_tdata[3*IW-1:2*IW]),
        .in_comp      (s_tdata[VEC_LSB-1:3*IW]),
        .in_vec       (in_vec),
        .out_valid    (c_valid),
        .out_item     (c_item),
        .out_addr     (c_addr),
        .out_in_range (c_in_range)
    );

    // Store access: writes land in order, so a later read sees them
    assign mem_wr_en = c_valid && (c_item.action == ftvm_pkg::ACT_WRITE) && c_in_range
                       && (c_item.comp < CPW'(ftvm_pkg::COMPONENTS));
    assign mem_rd_en = c_valid && (c_item.action == ftvm_pkg::ACT_MULT);

    ftvm_tensor_mem #(
        .QUAD_DEPTH (QUAD_DEPTH)
    ) u_tensor_mem (
        .aclk    (aclk),
        .addr    (c_addr),
        .wr_en   (mem_wr_en),
        .wr_comp (c_item.comp),
        .wr_data (c_item.vec.x),
        .rd_en   (mem_rd_en),
        .rd_data (mem_rd_data)
    );

    // Side data aligned with the memory read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else begin
            d_valid_reg <= mem_rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        d_zero_reg <= !c_in_range;
        d_neg_reg  <= c_item.neg;
        d_vec_reg  <= c_item.vec;
    end

    ftvm_mac u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (d_valid_reg),
        .in_zero    (d_zero_reg),
        .in_tensor  (mem_rd_data),
        .in_vec     (d_vec_reg),
        .in_neg     (d_neg_reg),
        .out_valid  (mac_valid),
        .out_result (mac_result)
    );

    ftvm_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (mac_valid),
        .push_data (mac_result),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (fifo_data)
    );

    assign m_tdata = fifo_data;

endmodule

FILE: verif/fourier_tensor_vector_multiply_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fourier_tensor_vector_multiply_core_test : self-checking bench of the core
// Loads complex tensor words and sends grid points with complex vectors. Each
// expected product is worked out from a local copy of the store and the
// registers and checked field by field against m_tdata. Random idling on both
// streams, drains before register changes, several register settings.
// ----------------------------------------------------------------------------
module fourier_tensor_vector_multiply_core_test;
    import ftvm_pkg::*;

    // Spare register and component codes that the core must ignore
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = 3'd7;
    localparam logic [COMP_W-1:0]    COMP_SPARE_LO = 3'd6;
    localparam logic [COMP_W-1:0]    COMP_SPARE_HI = 3'd7;

    // s_tdata layout, lowest field last
    typedef struct packed {
        logic [WORD_W-1:0] vz_im;
        logic [WORD_W-1:0] vz_re;
        logic [WORD_W-1:0] vy_im;
        logic [WORD_W-1:0] vy_re;
        logic [WORD_W-1:0] vx_im;
        logic [WORD_W-1:0] vx_re;
        logic [COMP_W-1:0] comp;
        logic [IDX_W-1:0]  z_idx;
        logic [IDX_W-1:0]  y_idx;
        logic [IDX_W-1:0]  x_idx;
    } point_payload_t;

    // Tensor store copy, register copy and queue of awaited products
    class tensor_product_ledger;
        logic [2*WORD_W-1:0]  words [int];
        cfg_t                 regs;
        logic [M_TDATA_W-1:0] pending_products [$];
        string field_names [6] = '{"rx_re", "rx_im", "ry_re", "ry_im", "rz_re", "rz_im"};
        int faults, checked, writes, mults, saturated;

        function new();
            regs = CFG_RESET;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_QUAD_X:   regs.quad_x   = val;
                REG_QUAD_Y:   regs.quad_y   = val;
                REG_QUAD_Z:   regs.quad_z   = val;
                REG_PADDED_X: regs.padded_x = val;
                REG_PADDED_Y: regs.padded_y = val;
                REG_PADDED_Z: regs.padded_z = val;
                default: ;
            endcase
        endfunction

        function int point_addr(int x, int y, int z);
            return x + int'(regs.quad_x) * (y + int'(regs.quad_y) * z);
        endfunction

        // Mirror each index past its quadrant, flipping that axis's sign
        function int mirror_addr(int xi, int yi, int zi, output int sx, output int sy,
                                 output int sz);
            int x, y, z;
            x = xi; y = yi; z = zi;
            sx = 1; sy = 1; sz = 1;
            if (x >= int'(regs.quad_x)) begin
                x = (int'(regs.padded_x) - x) & 255;
                sx = -1;
            end
            if (y >= int'(regs.quad_y)) begin
                y = (int'(regs.padded_y) - y) & 255;
                sy = -1;
            end
            if (z >= int'(regs.quad_z)) begin
                z = (int'(regs.padded_z) - z) & 255;
                sz = -1;
            end
            return point_addr(x, y, z);
        endfunction

        function bit is_loaded(int addr);
            for (int c = 0; c < COMPONENTS; c++)
                if (!words.exists(c * QUAD_DEPTH + addr)) return 0;
            return 1;
        endfunction

        // Adds sgn * (w * v) exactly
        function void fold_term(inout logic signed [71:0] re, inout logic signed [71:0] im,
                                input logic [2*WORD_W-1:0] w,
                                input logic signed [WORD_W-1:0] vr,
                                input logic signed [WORD_W-1:0] vi, input int sgn);
            logic signed [WORD_W-1:0] wr, wi;
            logic signed [71:0] tr, ti;
            wr = w[WORD_W-1:0];
            wi = w[2*WORD_W-1:WORD_W];
            tr = wr * vr - wi * vi;
            ti = wr * vi + wi * vr;
            if (sgn < 0) begin
                tr = -tr;
                ti = -ti;
            end
            re += tr;
            im += ti;
        endfunction

        // Round half up to Q8.24, then clamp to 32 bits
        function logic [WORD_W-1:0] round_sat(logic signed [71:0] a);
            logic signed [71:0] r;
            r = (a + (72'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (r > 72'sd2147483647) begin
                saturated++;
                return SAT_POS;
            end
            if (r < -72'sd2147483648) begin
                saturated++;
                return SAT_NEG;
            end
            return r[WORD_W-1:0];
        endfunction

        function void note_item(action_e act, point_payload_t p);
            int addr;
            int s [AXES];
            logic [2*WORD_W-1:0] m [COMPONENTS];
            logic signed [WORD_W-1:0] v [6];
            logic signed [71:0] acc [6];
            logic [M_TDATA_W-1:0] want;
            if (act == ACT_WRITE) begin
                writes++;
                addr = point_addr(p.x_idx, p.y_idx, p.z_idx);
                if (p.comp < COMPONENTS && addr < QUAD_DEPTH)
                    words[int'(p.comp) * QUAD_DEPTH + addr] = {p.vx_im, p.vx_re};
                return;
            end
            mults++;
            addr = mirror_addr(p.x_idx, p.y_idx, p.z_idx, s[0], s[1], s[2]);
            for (int c = 0; c < COMPONENTS; c++) begin
                m[c] = '0;
                if (addr < QUAD_DEPTH && words.exists(c * QUAD_DEPTH + addr))
                    m[c] = words[c * QUAD_DEPTH + addr];
            end
            v = '{p.vx_re, p.vx_im, p.vy_re, p.vy_im, p.vz_re, p.vz_im};
            foreach (acc[i]) acc[i] = '0;
            for (int r = 0; r < AXES; r++)
                for (int k = 0; k < AXES; k++)
                    fold_term(acc[2*r], acc[2*r+1], m[COMP_MAP[r][k]], v[2*k], v[2*k+1],
                              (r == k) ? 1 : s[r] * s[k]);
            for (int i = 0; i < 6; i++) want[WORD_W*i +: WORD_W] = round_sat(acc[i]);
            pending_products.push_back(want);
        endfunction

        function void check_product(logic [M_TDATA_W-1:0] got);
            logic [M_TDATA_W-1:0] want;
            if (pending_products.size() == 0) begin
                $error("result with none awaited: %h", got);
                faults++;
                return;
            end
            want = pending_products.pop_front();
            checked++;
            for (int i = 0; i < 6; i++)
                if (got[WORD_W*i +: WORD_W] !== want[WORD_W*i +: WORD_W]) begin
                    $error("%s: expected %h, actual %h", field_names[i],
                           want[WORD_W*i +: WORD_W], got[WORD_W*i +: WORD_W]);
                    faults++;
                end
        endfunction
    endclass

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata   = '0;
    logic [S_TUSER_W-1:0]    s_tuser   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_wdata = '0;

    tensor_product_ledger board = new();
    bit steady;
    int sent, settings;

    fourier_tensor_vector_multiply_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Mostly short gaps, a few long ones, none in steady phases
    function automatic int idle_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Full range, around unity, the extremes and zero
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 10))
            0, 1, 2, 3: return $urandom;
            4, 5, 6, 7: return $urandom_range(0, 1 << 27) - (1 << 26);
            8:          return SAT_POS;
            9:          return SAT_NEG;
            default:    return '0;
        endcase
    endfunction

    function automatic point_payload_t make_payload(logic [IDX_W-1:0] x, logic [IDX_W-1:0] y,
            logic [IDX_W-1:0] z, logic [COMP_W-1:0] c, logic [WORD_W-1:0] a0,
            logic [WORD_W-1:0] a1, logic [WORD_W-1:0] a2, logic [WORD_W-1:0] a3,
            logic [WORD_W-1:0] a4, logic [WORD_W-1:0] a5);
        point_payload_t p;
        p.x_idx = x; p.y_idx = y; p.z_idx = z; p.comp = c;
        p.vx_re = a0; p.vx_im = a1; p.vy_re = a2; p.vy_im = a3; p.vz_re = a4; p.vz_im = a5;
        return p;
    endfunction

    // Grid point that writes to a linear address, if the index widths allow
    function automatic bit split_addr(int addr, output logic [IDX_W-1:0] x,
                                      output logic [IDX_W-1:0] y, output logic [IDX_W-1:0] z);
        int qx, qxy, zi, yi, xi, rem;
        qx  = board.regs.quad_x;
        qxy = qx * int'(board.regs.quad_y);
        zi  = addr / qxy;
        if (zi > 127) zi = 127;
        rem = addr - zi * qxy;
        yi  = rem / qx;
        if (yi > 127) yi = 127;
        xi  = rem - yi * qx;
        x = xi; y = yi; z = zi;
        return xi <= 127;
    endfunction

    // Index inside the quadrant, or now and then its mirror partner
    function automatic int partner(int i, int q, int p);
        int m;
        m = p - i;
        if ($urandom_range(0, 1) && m >= q && m <= 127) return m;
        return i;
    endfunction

    // One input transaction; valid stays up unless a gap follows
    task automatic send(action_e act, point_payload_t p);
        int gap;
        s_tdata  <= p;
        s_tuser  <= act;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_item(act, p);
        sent++;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic multiply(int x, int y, int z);
        send(ACT_MULT, make_payload(x, y, z, $urandom_range(0, 7), pick_word(), pick_word(),
                                    pick_word(), pick_word(), pick_word(), pick_word()));
    endtask

    // Six tensor words at one linear address, starting at a random component
    task automatic load_point(int addr);
        logic [IDX_W-1:0] x, y, z;
        int first;
        void'(split_addr(addr, x, y, z));
        first = $urandom_range(0, COMPONENTS - 1);
        for (int i = 0; i < COMPONENTS; i++)
            send(ACT_WRITE, make_payload(x, y, z, (first + i) % COMPONENTS, pick_word(),
                                         pick_word(), $urandom, $urandom, $urandom, $urandom));
    endtask

    // Sender idle until every awaited product is back, plus pipeline slack
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (board.pending_products.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic program_regs(int qx, int qy, int qz, int px, int py, int pz, bit spare);
        logic [CFG_IDX_W-1:0] idx [8];
        logic [CFG_W-1:0]     val [8];
        int n;
        idx = '{REG_QUAD_X, REG_QUAD_Y, REG_QUAD_Z, REG_PADDED_X, REG_PADDED_Y, REG_PADDED_Z,
                REG_SPARE_LO, REG_SPARE_HI};
        val = '{qx, qy, qz, px, py, pz, $urandom, $urandom};
        n = spare ? 8 : 6;
        for (int i = 0; i < n; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            board.set_reg(idx[i], val[i]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    // Multiply at a point whose mirrored address is loaded or beyond the store
    task automatic random_product();
        int x, y, z, addr, sx, sy, sz, qx, qy, qz;
        bit placed;
        logic [IDX_W-1:0] wx, wy, wz;
        qx = board.regs.quad_x;
        qy = board.regs.quad_y;
        qz = board.regs.quad_z;
        placed = 0;
        for (int tries = 0; tries < 8 && !placed; tries++) begin
            if ($urandom_range(0, 1)) begin
                x = $urandom_range(0, 127);
                y = $urandom_range(0, 127);
                z = $urandom_range(0, 127);
            end else begin
                x = partner($urandom_range(0, qx - 1), qx, board.regs.padded_x);
                y = partner($urandom_range(0, qy - 1), qy, board.regs.padded_y);
                z = partner($urandom_range(0, qz - 1), qz, board.regs.padded_z);
            end
            addr = board.mirror_addr(x, y, z, sx, sy, sz);
            if (addr >= QUAD_DEPTH) begin
                placed = ($urandom_range(0, 3) == 0);
            end else if (split_addr(addr, wx, wy, wz)) begin
                if (!board.is_loaded(addr) || $urandom_range(0, 6) == 0) load_point(addr);
                placed = 1;
            end
        end
        // fall back on a plain quadrant point, pulled into the store
        if (!placed) begin
            x = $urandom_range(0, qx - 1);
            y = $urandom_range(0, qy - 1);
            z = $urandom_range(0, qz - 1);
            if (board.point_addr(x, y, z) >= QUAD_DEPTH) z = 0;
            if (board.point_addr(x, y, z) >= QUAD_DEPTH) y = 0;
            if (!board.is_loaded(board.point_addr(x, y, z))) load_point(board.point_addr(x, y, z));
        end
        multiply(x, y, z);
    endtask

    // Result side: random back-pressure
    initial begin
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = idle_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    // Check every result transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_product(m_tdata);
    end

    initial begin
        #20000000;
        $display("fourier_tensor_vector_multiply_core: mismatch");
        $finish;
    end

    initial begin
        int goal, midpoint, qx, qy, qz;
        bit paused;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes at point (1,2,3), address 12417 under reset settings
        send(ACT_WRITE, make_payload(1, 2, 3, COMP_XX, SAT_POS, SAT_POS, 0, 0, 0, 0));
        send(ACT_WRITE, make_payload(1, 2, 3, COMP_XY, SAT_NEG, SAT_NEG, 0, 0, 0, 0));
        send(ACT_WRITE, make_payload(1, 2, 3, COMP_XZ, SAT_POS, SAT_NEG, 0, 0, 0, 0));
        send(ACT_WRITE, make_payload(1, 2, 3, COMP_YY, 0, 0, 0, 0, 0, 0));
        send(ACT_WRITE, make_payload(1, 2, 3, COMP_YZ, 32'h0100_0000, 32'hFF00_0000,
                                     0, 0, 0, 0));
        send(ACT_WRITE, make_payload(1, 2, 3, COMP_ZZ, pick_word(), pick_word(), 0, 0, 0, 0));
        send(ACT_MULT, make_payload(1, 2, 3, COMP_XX, SAT_POS, SAT_POS, SAT_POS, SAT_POS,
                                    SAT_POS, SAT_POS));
        // all three axes mirrored back onto the same point
        send(ACT_MULT, make_payload(127, 126, 125, COMP_XX, SAT_NEG, SAT_NEG, SAT_NEG,
                                    SAT_NEG, SAT_NEG, SAT_NEG));
        // spare components leave the store alone
        send(ACT_WRITE, make_payload(1, 2, 3, COMP_SPARE_LO, $urandom, $urandom, 0, 0, 0, 0));
        send(ACT_WRITE, make_payload(1, 2, 3, COMP_SPARE_HI, $urandom, $urandom, 0, 0, 0, 0));
        // over-wide x index on write lands on the same linear address
        send(ACT_WRITE, make_payload(65, 1, 3, COMP_XX, 32'h0080_0000, 32'hFFC0_0000,
                                     0, 0, 0, 0));
        multiply(1, 2, 3);
        // write and read beyond the store
        send(ACT_WRITE, make_payload(0, 0, 100, COMP_XX, $urandom, $urandom, 0, 0, 0, 0));
        multiply(0, 0, 8);
        // top word of the store, reached through mirroring
        load_point(QUAD_DEPTH - 1);
        multiply(65, 65, 121);

        // Random phases over several register settings
        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                quiesce();
                case (ph)
                    1: program_regs(1, 1, 1, 1, 1, 1, 0);
                    2: program_regs(128, 128, 128, 128, 128, 128, 0);
                    3: program_regs(8, 16, 4, 16, 32, 8, 1);
                    default: begin
                        qx = $urandom_range(1, 32);
                        qy = $urandom_range(1, 32);
                        qz = $urandom_range(1, 32);
                        if ($urandom_range(0, 9) < 7)
                            program_regs(qx, qy, qz, 2 * qx, 2 * qy, 2 * qz, 0);
                        else
                            program_regs(qx, qy, qz, $urandom_range(1, 128),
                                         $urandom_range(1, 128), $urandom_range(1, 128), 0);
                    end
                endcase
            end
            steady   = (ph == 2 || ph == 5);
            goal     = sent + 170;
            midpoint = sent + 85;
            paused   = 0;
            while (sent < goal) begin
                if (!paused && sent >= midpoint) begin
                    quiesce();
                    paused = 1;
                end
                if ($urandom_range(0, 9) == 0)
                    send(ACT_WRITE, make_payload($urandom, $urandom, $urandom,
                                                 $urandom_range(0, 7), pick_word(), pick_word(),
                                                 $urandom, $urandom, $urandom, $urandom));
                else
                    random_product();
            end
        end

        quiesce();
        $display("Sent %0d transactions (%0d tensor writes, %0d multiplies) over %0d settings;",
                 sent, board.writes, board.mults, settings + 1);
        $display("checked %0d products, %0d fields clamped.", board.checked, board.saturated);
        if (board.faults == 0) begin
            $display("fourier_tensor_vector_multiply_core: match");
        end else begin
            $display("fourier_tensor_vector_multiply_core: mismatch");
        end
        $finish;
    end

endmodule
